// File: rtl/core/rfc_pkg.sv
// Shared constants, status codes and divider word types for the reciprocal frequency counter.
package rfc_pkg;

   // Field widths and fixed-point format
   localparam int COUNT_BITS    = 24;
   localparam int FRACTION_BITS = 16;
   localparam int TIME_BITS     = 32;
   localparam int FREQ_BITS     = 48;
   localparam int SEEN_BITS     = 24;
   localparam int STATUS_BITS   = 2;

   // Product clock_hz * (edges - 1), then shifted up by the fraction bits
   localparam int NUM_BITS = TIME_BITS + COUNT_BITS;
   localparam int DIV_BITS = NUM_BITS + FRACTION_BITS;

   localparam logic [TIME_BITS-1:0] CLOCK_RESET = 32'd50000000;

   // Item kinds
   localparam logic KIND_EDGE = 1'b0;
   localparam logic KIND_GATE = 1'b1;

   // Result status codes
   localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FEW_EDGES = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_SATURATED = 2'd2;

   // Sequencer to divider
   typedef struct packed {
      logic                 start;
      logic [DIV_BITS-1:0]  dividend;
      logic [TIME_BITS-1:0] divisor;
   } div_req_type;

   // Divider to sequencer
   typedef struct packed {
      logic                 done;
      logic                 overflow;
      logic [FREQ_BITS-1:0] quotient;
   } div_rsp_type;

endpackage

// File: rtl/core/rfc_if.sv
// Valid/ready channel interfaces for the request and response words.
interface rfc_req_if import rfc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 kind;
   logic [TIME_BITS-1:0] timestamp;

   modport source (output valid, output kind, output timestamp, input ready);
   modport sink   (input valid, input kind, input timestamp, output ready);
endinterface

interface rfc_rsp_if import rfc_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [FREQ_BITS-1:0]   frequency_q16;
   logic [SEEN_BITS-1:0]   edges_seen;
   logic [STATUS_BITS-1:0] status;

   modport source (output valid, output frequency_q16, output edges_seen, output status,
                   input ready);
   modport sink   (input valid, input frequency_q16, input edges_seen, input status,
                   output ready);
endinterface

// File: rtl/core/reciprocal_frequency_counter.sv
// Reciprocal frequency counter: edge window tracking, gate sequencer and result register.
// Edge words are taken one per cycle, back to back, while the sequencer is idle. A gate whose
// edge count is below two goes straight to the result, one over a zero span goes through multiply
// and span check, else multiply, span check, divide at one quotient bit per cycle, result.
// No word is taken meanwhile, nor while a finished result waits for the output register.
// Synchronous active-high reset clears the window, loads clock_hz = 50 MHz, drops rsp valid.
module reciprocal_frequency_counter import rfc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   rfc_req_if.sink              req_bus,
   rfc_rsp_if.source            rsp_bus,
   input  logic                 csr_write_enable,
   input  logic [TIME_BITS-1:0] csr_write_data
);

   localparam int WIDE_BITS = (COUNT_BITS > SEEN_BITS) ? COUNT_BITS : SEEN_BITS;
   localparam logic [SEEN_BITS-1:0] SEEN_MAX = {SEEN_BITS{1'b1}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULT,
      ST_CHECK,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   state_type              state_ff, state_in;

   // Window state and configuration
   logic [TIME_BITS-1:0]   clock_ff, clock_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [TIME_BITS-1:0]   ref_ff, ref_in;
   logic [TIME_BITS-1:0]   latest_ff, latest_in;
   logic                   have_ref_ff, have_ref_in;

   // Gate snapshot and working values
   logic [COUNT_BITS-1:0]  snap_count_ff, snap_count_in;
   logic [TIME_BITS-1:0]   span_ff, span_in;
   logic [NUM_BITS-1:0]    prod_ff, prod_in;
   logic [SEEN_BITS-1:0]   seen_ff, seen_in;
   logic [FREQ_BITS-1:0]   res_freq_ff, res_freq_in;
   logic [STATUS_BITS-1:0] res_status_ff, res_status_in;

   // Output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [FREQ_BITS-1:0]   rsp_freq_ff, rsp_freq_in;
   logic [SEEN_BITS-1:0]   rsp_seen_ff, rsp_seen_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;

   div_req_type            div_req;
   div_rsp_type            div_rsp;

   logic                   req_take;
   logic [WIDE_BITS-1:0]   count_wide;
   logic [COUNT_BITS-1:0]  snap_dec;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_take      = req_bus.valid && (state_ff == ST_IDLE);
   assign count_wide    = WIDE_BITS'(count_ff);
   assign snap_dec      = snap_count_ff - 1'b1;

   // Numerator clock_hz * (edges - 1)
   assign prod_in = {{COUNT_BITS{1'b0}}, clock_ff} * {{TIME_BITS{1'b0}}, snap_dec};

   // Divider launch: fixed-point dividend over the timestamp span
   assign div_req.start    = (state_ff == ST_CHECK) && (span_ff != '0);
   assign div_req.dividend = DIV_BITS'(prod_ff) << FRACTION_BITS;
   assign div_req.divisor  = span_ff;

   rfc_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Sequencer and window update
   always_comb begin
      state_in      = state_ff;
      clock_in      = csr_write_enable ? csr_write_data : clock_ff;
      count_in      = count_ff;
      ref_in        = ref_ff;
      latest_in     = latest_ff;
      have_ref_in   = have_ref_ff;
      snap_count_in = snap_count_ff;
      span_in       = span_ff;
      seen_in       = seen_ff;
      res_freq_in   = res_freq_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_freq_in   = rsp_freq_ff;
      rsp_seen_in   = rsp_seen_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_bus.kind == KIND_EDGE) begin
                  latest_in = req_bus.timestamp;
                  if (count_ff != '1) begin
                     count_in = count_ff + 1'b1;
                  end
                  if (!have_ref_ff) begin
                     have_ref_in = 1'b1;
                     ref_in      = req_bus.timestamp;
                  end
               end else begin
                  // gate: snapshot the window, then clear it
                  snap_count_in = count_ff;
                  span_in       = latest_ff - ref_ff;
                  seen_in       = (count_wide > WIDE_BITS'(SEEN_MAX)) ?
                                  SEEN_MAX : count_wide[SEEN_BITS-1:0];
                  count_in      = '0;
                  ref_in        = '0;
                  latest_in     = '0;
                  have_ref_in   = 1'b0;
                  if (count_ff < COUNT_BITS'(2)) begin
                     res_freq_in   = '0;
                     res_status_in = STATUS_FEW_EDGES;
                     state_in      = ST_DONE;
                  end else begin
                     state_in = ST_MULT;
                  end
               end
            end
         end
         ST_MULT: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            // zero span: unbounded unless the numerator is zero too
            if (span_ff == '0) begin
               if (prod_ff == '0) begin
                  res_freq_in   = '0;
                  res_status_in = STATUS_OK;
               end else begin
                  res_freq_in   = '1;
                  res_status_in = STATUS_SATURATED;
               end
               state_in = ST_DONE;
            end else begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_rsp.done) begin
               if (div_rsp.overflow) begin
                  res_freq_in   = '1;
                  res_status_in = STATUS_SATURATED;
               end else begin
                  res_freq_in   = div_rsp.quotient;
                  res_status_in = STATUS_OK;
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hand the result over once the output register is free
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_freq_in   = res_freq_ff;
               rsp_seen_in   = seen_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         clock_ff     <= CLOCK_RESET;
         count_ff     <= '0;
         ref_ff       <= '0;
         latest_ff    <= '0;
         have_ref_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clock_ff     <= clock_in;
         count_ff     <= count_in;
         ref_ff       <= ref_in;
         latest_ff    <= latest_in;
         have_ref_ff  <= have_ref_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      snap_count_ff <= snap_count_in;
      span_ff       <= span_in;
      prod_ff       <= prod_in;
      seen_ff       <= seen_in;
      res_freq_ff   <= res_freq_in;
      res_status_ff <= res_status_in;
      rsp_freq_ff   <= rsp_freq_in;
      rsp_seen_ff   <= rsp_seen_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.frequency_q16 = rsp_freq_ff;
   assign rsp_bus.edges_seen    = rsp_seen_ff;
   assign rsp_bus.status        = rsp_status_ff;

endmodule

// File: rtl/core/rfc_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle, overflow past the result width.
module rfc_divider import rfc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int CNT_BITS = $clog2(DIV_BITS + 1);

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [DIV_BITS-1:0]  dvd_ff, dvd_in;
   logic [TIME_BITS-1:0] dvs_ff, dvs_in;
   logic [TIME_BITS-1:0] rem_ff, rem_in;
   logic [FREQ_BITS-1:0] quo_ff, quo_in;
   logic                 ovf_ff, ovf_in;

   logic [TIME_BITS:0]   rem_shift;
   logic [TIME_BITS:0]   rem_diff;
   logic                 fits;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   assign rem_shift = {rem_ff, dvd_ff[DIV_BITS-1]};
   assign rem_diff  = rem_shift - {1'b0, dvs_ff};
   assign fits      = rem_shift >= {1'b0, dvs_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      ovf_in  = ovf_ff;
      if (div_req.start) begin
         run_in = 1'b1;
         cnt_in = CNT_BITS'(DIV_BITS);
         dvd_in = div_req.dividend;
         dvs_in = div_req.divisor;
         rem_in = '0;
         quo_in = '0;
         ovf_in = 1'b0;
      end else if (run_ff) begin
         rem_in = fits ? rem_diff[TIME_BITS-1:0] : rem_shift[TIME_BITS-1:0];
         quo_in = {quo_ff[FREQ_BITS-2:0], fits};
         // a set bit leaving the top means the quotient is too wide
         ovf_in = ovf_ff | quo_ff[FREQ_BITS-1];
         dvd_in = {dvd_ff[DIV_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.overflow = ovf_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// File: rtl/core/rfc_checker.sv
// Port-level assertions for the reciprocal frequency counter and their bind.
module rfc_checker import rfc_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   req_kind,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [FREQ_BITS-1:0]   rsp_frequency_q16,
   input logic [SEEN_BITS-1:0]   rsp_edges_seen,
   input logic [STATUS_BITS-1:0] rsp_status
);

   // A result word stays offered until it is taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped before handshake");

   // A gate word leaves the idle state, so no word is taken in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_kind == KIND_GATE) |=> !req_ready)
      else $error("request taken right after a gate word");

   // A result whose edges_seen is 0 or 1 always reports the few-edges status
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_edges_seen < SEEN_BITS'(2)) |-> (rsp_status == STATUS_FEW_EDGES))
      else $error("short window without few-edges status");

   // Few-edges status carries a zero frequency
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_FEW_EDGES) |-> (rsp_frequency_q16 == '0))
      else $error("few-edges result with nonzero frequency");

   // Saturated status carries the all-ones frequency
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_SATURATED) |-> (rsp_frequency_q16 == '1))
      else $error("saturated result not at maximum");

endmodule

bind reciprocal_frequency_counter rfc_checker u_rfc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .req_kind          (req_bus.kind),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_frequency_q16 (rsp_bus.frequency_q16),
   .rsp_edges_seen    (rsp_bus.edges_seen),
   .rsp_status        (rsp_bus.status)
);
